/* rtl/srv_pkg.sv */
`timescale 1ns / 1ps

package srv_pkg;

  localparam int SAMPLE_W = 24;
  localparam int WORD_W   = 32;
  localparam int COEF_W   = 16;
  localparam int WIDE     = 50;

  typedef logic signed [WIDE-1:0] wide_t;

  localparam logic [COEF_W-1:0] Q15_ONE = 16'h8000;
  localparam logic [COEF_W-1:0] FB_BASE = 16'd22938;
  localparam logic [COEF_W-1:0] FB_SPAN = 16'd9175;

  localparam logic [1:0] REG_ROOM    = 2'd0;
  localparam logic [1:0] REG_DAMPING = 2'd1;
  localparam logic [1:0] REG_WET_MIX = 2'd2;

  localparam wide_t RND_HALF = {{(WIDE-15){1'b0}}, 15'h4000};
  localparam wide_t S32_MAX  = {{(WIDE-31){1'b0}}, {31{1'b1}}};
  localparam wide_t S32_MIN  = {{(WIDE-31){1'b1}}, {31{1'b0}}};
  localparam wide_t S24_MAX  = {{(WIDE-23){1'b0}}, {23{1'b1}}};
  localparam wide_t S24_MIN  = {{(WIDE-23){1'b1}}, {23{1'b0}}};

  function automatic wide_t round15(input wide_t p);
    return (p + RND_HALF) >>> 15;
  endfunction

  function automatic wide_t half(input wide_t v);
    return (v + wide_t'(1)) >>> 1;
  endfunction

  function automatic logic signed [WORD_W-1:0] sat32(input wide_t v);
    logic signed [WORD_W-1:0] r;
    if (v > S32_MAX) begin
      r = S32_MAX[WORD_W-1:0];
    end else if (v < S32_MIN) begin
      r = S32_MIN[WORD_W-1:0];
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat24(input wide_t v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > S24_MAX) begin
      r = S24_MAX[SAMPLE_W-1:0];
    end else if (v < S24_MIN) begin
      r = S24_MIN[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] clip_coef(input logic [COEF_W-1:0] r);
    return (r > Q15_ONE) ? Q15_ONE : r;
  endfunction

endpackage

/* rtl/schroeder_reverb.sv */
`timescale 1ns / 1ps

// Schroeder reverberator: four damped comb filters in parallel, averaged and fed through
// two series allpasses, then mixed with the dry sample by wet_mix. One Q1.23 sample in
// gives one saturated Q1.23 sample out. All products run on one shared 33x17 multiplier under a
// sequencer, and every delay line sits in one of two single-write memories (combs,
// allpasses). Each comb steps through read, two lowpass products, round, feedback product
// and write, each allpass through read and write, and the sequence also covers feedback
// setup, averaging and the final mix. The result waits in an output register, so the next
// item is taken while it is still pending. After reset the block runs a clearing pass that
// zeroes both delay memories, during which no item is accepted; configuration writes are
// taken at any time.
module schroeder_reverb
  import srv_pkg::*;
#(
  parameter int COMB_LEN_0    = 1116,
  parameter int COMB_LEN_1    = 1188,
  parameter int COMB_LEN_2    = 1277,
  parameter int COMB_LEN_3    = 1356,
  parameter int ALLPASS_LEN_0 = 556,
  parameter int ALLPASS_LEN_1 = 441
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [COEF_W-1:0]          cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample_out
);

  localparam int COMB_TOTAL = COMB_LEN_0 + COMB_LEN_1 + COMB_LEN_2 + COMB_LEN_3;
  localparam int AP_TOTAL   = ALLPASS_LEN_0 + ALLPASS_LEN_1;
  localparam int CLR_LEN    = (COMB_TOTAL > AP_TOTAL) ? COMB_TOTAL : AP_TOTAL;
  localparam int CMAX01     = (COMB_LEN_0 > COMB_LEN_1) ? COMB_LEN_0 : COMB_LEN_1;
  localparam int CMAX23     = (COMB_LEN_2 > COMB_LEN_3) ? COMB_LEN_2 : COMB_LEN_3;
  localparam int CMAX       = (CMAX01 > CMAX23) ? CMAX01 : CMAX23;
  localparam int AMAX       = (ALLPASS_LEN_0 > ALLPASS_LEN_1) ? ALLPASS_LEN_0 : ALLPASS_LEN_1;
  localparam int CAW        = $clog2(COMB_TOTAL);
  localparam int AAW        = $clog2(AP_TOTAL);
  localparam int CPW        = $clog2(CMAX + 1);
  localparam int APW        = $clog2(AMAX + 1);
  localparam int CLW        = $clog2(CLR_LEN + 1);

  localparam logic [CAW-1:0] COMB_BASE [4] = '{
    CAW'(0), CAW'(COMB_LEN_0), CAW'(COMB_LEN_0 + COMB_LEN_1),
    CAW'(COMB_LEN_0 + COMB_LEN_1 + COMB_LEN_2)};
  localparam logic [CPW-1:0] COMB_LEN [4] = '{
    CPW'(COMB_LEN_0), CPW'(COMB_LEN_1), CPW'(COMB_LEN_2), CPW'(COMB_LEN_3)};
  localparam logic [AAW-1:0] AP_BASE [2] = '{AAW'(0), AAW'(ALLPASS_LEN_0)};
  localparam logic [APW-1:0] AP_LEN [2]  = '{APW'(ALLPASS_LEN_0), APW'(ALLPASS_LEN_1)};

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FB    = 4'd2;
  localparam logic [3:0] S_FB2   = 4'd3;
  localparam logic [3:0] S_C_RD  = 4'd4;
  localparam logic [3:0] S_C_M0  = 4'd5;
  localparam logic [3:0] S_C_M1  = 4'd6;
  localparam logic [3:0] S_C_M2  = 4'd7;
  localparam logic [3:0] S_C_M3  = 4'd8;
  localparam logic [3:0] S_C_WR  = 4'd9;
  localparam logic [3:0] S_WET   = 4'd10;
  localparam logic [3:0] S_A_RD  = 4'd11;
  localparam logic [3:0] S_A_WR  = 4'd12;
  localparam logic [3:0] S_O_M0  = 4'd13;
  localparam logic [3:0] S_O_M1  = 4'd14;
  localparam logic [3:0] S_O_M2  = 4'd15;

  logic [3:0]               state;
  logic [CLW-1:0]           clr_cnt;
  logic [1:0]               ci;
  logic                     aj;

  logic [COEF_W-1:0]        room;
  logic [COEF_W-1:0]        damping;
  logic [COEF_W-1:0]        wet_mix;
  logic [COEF_W-1:0]        room_c;
  logic [COEF_W-1:0]        d_c;
  logic [COEF_W-1:0]        m_c;
  logic [COEF_W-1:0]        fb;

  logic signed [SAMPLE_W-1:0] x;
  logic signed [WORD_W-1:0] lp [4];
  logic [CPW-1:0]           comb_pos [4];
  logic [APW-1:0]           ap_pos [2];
  logic signed [WORD_W+1:0] sum;
  logic signed [WORD_W-1:0] wet;

  logic signed [WORD_W:0]   opa;
  logic signed [COEF_W:0]   opb;
  wide_t                    prod;
  wide_t                    acc;

  logic signed [WORD_W-1:0] comb_mem [COMB_TOTAL];
  logic signed [WORD_W-1:0] ap_mem [AP_TOTAL];
  logic signed [WORD_W-1:0] comb_q;
  logic signed [WORD_W-1:0] ap_q;
  logic                     comb_we;
  logic                     ap_we;
  logic [CAW-1:0]           comb_addr;
  logic [CAW-1:0]           comb_waddr;
  logic signed [WORD_W-1:0] comb_wdata;
  logic [AAW-1:0]           ap_addr;
  logic [AAW-1:0]           ap_waddr;
  logic signed [WORD_W-1:0] ap_wdata;
  logic                     clearing;
  logic                     commit;

  assign room_c   = clip_coef(room);
  assign d_c      = clip_coef(damping);
  assign m_c      = clip_coef(wet_mix);
  assign clearing = (state == S_CLEAR);
  assign in_stall = (state != S_IDLE);
  assign commit   = (state == S_O_M2) && (!out_valid || !out_stall);

  assign comb_addr = COMB_BASE[ci] + CAW'(comb_pos[ci]);
  assign ap_addr   = AP_BASE[aj] + AAW'(ap_pos[aj]);

  // shared multiplier operand select
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (state)
      S_FB: begin
        opa = signed'({17'd0, FB_SPAN});
        opb = signed'({1'b0, room_c});
      end
      S_C_M0: begin
        opa = signed'({comb_q[WORD_W-1], comb_q});
        opb = signed'({1'b0, Q15_ONE - d_c});
      end
      S_C_M1: begin
        opa = signed'({lp[ci][WORD_W-1], lp[ci]});
        opb = signed'({1'b0, d_c});
      end
      S_C_M3: begin
        opa = signed'({lp[ci][WORD_W-1], lp[ci]});
        opb = signed'({1'b0, fb});
      end
      S_O_M0: begin
        opa = signed'({{(WORD_W+1-SAMPLE_W){x[SAMPLE_W-1]}}, x});
        opb = signed'({1'b0, Q15_ONE - m_c});
      end
      S_O_M1: begin
        opa = signed'({wet[WORD_W-1], wet});
        opb = signed'({1'b0, m_c});
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_comb begin
    comb_we    = 1'b0;
    comb_waddr = comb_addr;
    comb_wdata = sat32(wide_t'(x) + round15(prod));
    ap_we      = 1'b0;
    ap_waddr   = ap_addr;
    ap_wdata   = sat32(wide_t'(wet) + half(wide_t'(ap_q)));
    if (clearing) begin
      comb_we    = (clr_cnt < CLW'(COMB_TOTAL));
      comb_waddr = clr_cnt[CAW-1:0];
      comb_wdata = '0;
      ap_we      = (clr_cnt < CLW'(AP_TOTAL));
      ap_waddr   = clr_cnt[AAW-1:0];
      ap_wdata   = '0;
    end else begin
      comb_we = (state == S_C_WR);
      ap_we   = (state == S_A_WR);
    end
  end

  always_ff @(posedge clk) begin
    if (comb_we) begin
      comb_mem[comb_waddr] <= comb_wdata;
    end
    comb_q <= comb_mem[comb_addr];
  end

  always_ff @(posedge clk) begin
    if (ap_we) begin
      ap_mem[ap_waddr] <= ap_wdata;
    end
    ap_q <= ap_mem[ap_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      room    <= 16'h4000;
      damping <= 16'h4000;
      wet_mix <= 16'h4000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROOM:    room    <= cfg_data;
        REG_DAMPING: damping <= cfg_data;
        REG_WET_MIX: wet_mix <= cfg_data;
        default:     ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state != S_O_M2) begin
      prod <= wide_t'(opa) * wide_t'(opb);
    end
    case (state) inside
      S_IDLE: begin
        x   <= sample_in;
        sum <= '0;
      end
      S_FB2: begin
        fb <= FB_BASE + COEF_W'(round15(prod));
      end
      S_C_M0: begin
        sum <= sum + (WORD_W+2)'(comb_q);
      end
      S_C_M1, S_O_M1: begin
        acc <= prod;
      end
      S_WET: begin
        wet <= sat32((wide_t'(sum) + wide_t'(2)) >>> 2);
      end
      S_A_WR: begin
        wet <= sat32(wide_t'(ap_q) - half(wide_t'(wet)));
      end
      S_O_M2: begin
        if (commit) begin
          sample_out <= sat24(round15(acc + prod));
        end
      end
      default: ;
    endcase
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      ci        <= '0;
      aj        <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        lp[i]       <= '0;
        comb_pos[i] <= '0;
      end
      ap_pos[0] <= '0;
      ap_pos[1] <= '0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLW'(CLR_LEN - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_FB;
          end
        end
        S_FB: begin
          state <= S_FB2;
        end
        S_FB2: begin
          ci    <= '0;
          state <= S_C_RD;
        end
        S_C_RD: begin
          state <= S_C_M0;
        end
        S_C_M0: begin
          state <= S_C_M1;
        end
        S_C_M1: begin
          state <= S_C_M2;
        end
        S_C_M2: begin
          lp[ci] <= sat32(round15(acc + prod));
          state  <= S_C_M3;
        end
        S_C_M3: begin
          state <= S_C_WR;
        end
        S_C_WR: begin
          comb_pos[ci] <= (comb_pos[ci] + 1'b1 == COMB_LEN[ci]) ? '0 : comb_pos[ci] + 1'b1;
          ci           <= ci + 1'b1;
          state        <= (ci == 2'd3) ? S_WET : S_C_RD;
        end
        S_WET: begin
          aj    <= 1'b0;
          state <= S_A_RD;
        end
        S_A_RD: begin
          state <= S_A_WR;
        end
        S_A_WR: begin
          ap_pos[aj] <= (ap_pos[aj] + 1'b1 == AP_LEN[aj]) ? '0 : ap_pos[aj] + 1'b1;
          aj         <= ~aj;
          state      <= aj ? S_O_M0 : S_A_RD;
        end
        S_O_M0: begin
          state <= S_O_M1;
        end
        S_O_M1: begin
          state <= S_O_M2;
        end
        S_O_M2: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
